// ----- hw/rtl/rgba_pixel_format_converter_top_macros.svh -----
// assertion macros for the pixel format converter checker
// needs clk and rst_n in the scope of each use
`ifndef RGBA_PIXEL_FORMAT_CONVERTER_TOP_MACROS_SVH
`define RGBA_PIXEL_FORMAT_CONVERTER_TOP_MACROS_SVH

// clocked assertion, held off while in reset
`define RPFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked implication, consequent checked in the next cycle
`define RPFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rpfc_pkg.sv -----
// shared types, conversion codes and channel helper functions
// for the rgba pixel format converter; no dependencies
package rpfc_pkg;

    localparam logic [2:0] CONV_U8_F32  = 3'd0;
    localparam logic [2:0] CONV_F16_F32 = 3'd1;
    localparam logic [2:0] CONV_U8_F16  = 3'd2;
    localparam logic [2:0] CONV_F32_F16 = 3'd3;
    localparam logic [2:0] CONV_F16_U8  = 3'd4;
    localparam logic [2:0] CONV_F32_U8  = 3'd5;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } rpfc_en_t;

    function automatic logic [2:0] msb8(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (v[i])
            begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [3:0] lead10(input logic [9:0] v);
        logic [3:0] idx;
        idx = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (v[i])
            begin
                idx = 4'(i);
            end
        end
        return idx;
    endfunction

    // u/255 is the byte u repeated forever, so the round bit is always set
    function automatic logic [31:0] unorm_to_f32(input logic [7:0] u);
        logic [2:0]  p;
        logic [7:0]  r;
        logic [23:0] m;
        logic [7:0]  e;
        p = msb8(u);
        r = u << (3'd7 - p);
        m = {r, r, r} + 24'd1;
        e = 8'd119 + {5'd0, p};
        if (u == 8'd0)
        begin
            return 32'h0000_0000;
        end
        else if (u == 8'hFF)
        begin
            return 32'h3F80_0000;
        end
        return {1'b0, e, m[22:0]};
    endfunction

    function automatic logic [31:0] half_to_f32(input logic [15:0] h);
        logic [4:0] ex;
        logic [9:0] man;
        logic [3:0] k;
        logic [9:0] ms;
        logic [7:0] e;
        ex  = h[14:10];
        man = h[9:0];
        k   = lead10(man);
        ms  = man << (4'd10 - k);
        e   = 8'd103 + {4'd0, k};
        if (ex == 5'd0)
        begin
            if (man == 10'd0)
            begin
                return {h[15], 31'd0};
            end
            return {h[15], e, ms, 13'd0};
        end
        else if (ex == 5'h1F)
        begin
            if (man == 10'd0)
            begin
                return {h[15], 31'h7F80_0000};
            end
            return {h[15], 31'h7FC0_0000 | {8'd0, man, 13'd0}};
        end
        return {h[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
    endfunction

endpackage

// ----- hw/rtl/rpfc_ctrl.sv -----
// valid tracking and stall control for the three stage pipeline
// depends on rpfc_pkg
module rpfc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_ready,
    output logic              in_ready,
    output logic              out_valid,
    output rpfc_pkg::rpfc_en_t en
);

    logic v1_reg, v2_reg, v3_reg;

    always_comb
    begin
        en.s3 = !v3_reg || out_ready;
        en.s2 = !v2_reg || en.s3;
        en.s1 = !v1_reg || en.s2;
    end

    assign in_ready  = en.s1;
    assign out_valid = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en.s1)
            begin
                v1_reg <= in_valid;
            end
            if (en.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (en.s3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

endmodule

// ----- hw/rtl/rpfc_channel.sv -----
// one channel datapath: decode to fp32, round or multiply, finish
// depends on rpfc_pkg
module rpfc_channel
(
    input  logic               clk,
    input  rpfc_pkg::rpfc_en_t en,
    input  logic [2:0]         req_type,
    input  logic [31:0]        din,
    output logic [31:0]        dout
);

    // stage 1: source to fp32
    logic [2:0]  code1_reg;
    logic [31:0] a1_reg;
    logic [31:0] a1_next;

    always_comb
    begin
        case (req_type) inside
            rpfc_pkg::CONV_U8_F32, rpfc_pkg::CONV_U8_F16:
                a1_next = rpfc_pkg::unorm_to_f32(din[7:0]);
            rpfc_pkg::CONV_F16_F32, rpfc_pkg::CONV_F16_U8:
                a1_next = rpfc_pkg::half_to_f32(din[15:0]);
            default:
                a1_next = din;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            code1_reg <= req_type;
            a1_reg    <= a1_next;
        end
    end

    // stage 2: half rounding prep or unorm product
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [23:0] m24;
    logic [4:0]  hsh;
    logic [23:0] rmask;
    logic [14:0] q_next;
    logic        inc_next;
    logic        zero_next;
    logic        sat_next;
    logic [31:0] prod_next;
    logic [4:0]  ush_next;

    logic [2:0]  code2_reg;
    logic [31:0] a2_reg;
    logic        sgn2_reg;
    logic [14:0] q2_reg;
    logic        inc2_reg;
    logic        zero2_reg;
    logic        sat2_reg;
    logic [31:0] prod2_reg;
    logic [4:0]  ush2_reg;

    always_comb
    begin
        sgn   = a1_reg[31];
        ex    = a1_reg[30:23];
        man   = a1_reg[22:0];
        m24   = {(ex != 8'd0), man};
        hsh   = 5'(8'd126 - ex);
        rmask = (24'd1 << (hsh - 5'd1)) - 24'd1;
        q_next   = 15'd0;
        inc_next = 1'b0;
        if (ex == 8'hFF)
        begin
            q_next = (man != 23'd0) ? (15'h7E00 | {5'd0, man[22:13]}) : 15'h7C00;
        end
        else if (ex >= 8'd143)
        begin
            q_next = 15'h7C00;
        end
        else if (ex <= 8'd112)
        begin
            if (ex >= 8'd102)
            begin
                q_next   = 15'(m24 >> hsh);
                inc_next = m24[hsh - 5'd1] && (((m24 & rmask) != 24'd0) || q_next[0]);
            end
        end
        else
        begin
            q_next   = {5'(ex - 8'd112), man[22:13]};
            inc_next = man[12] && ((man[11:0] != 12'd0) || q_next[0]);
        end

        zero_next = 1'b0;
        sat_next  = 1'b0;
        if ((ex == 8'hFF && man != 23'd0) || sgn || ex < 8'd119)
        begin
            zero_next = 1'b1;
        end
        else if (ex >= 8'd127)
        begin
            sat_next = 1'b1;
        end
        prod_next = {8'd0, 1'b1, man} * 32'd255;
        ush_next  = 5'(8'd150 - ex);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            code2_reg <= code1_reg;
            a2_reg    <= a1_reg;
            sgn2_reg  <= sgn;
            q2_reg    <= q_next;
            inc2_reg  <= inc_next;
            zero2_reg <= zero_next;
            sat2_reg  <= sat_next;
            prod2_reg <= prod_next;
            ush2_reg  <= ush_next;
        end
    end

    // stage 3: pass fp32 through, or apply rounding, truncate and saturate
    logic [24:0] rnd;
    logic [32:0] pr;
    logic [32:0] n;
    logic [31:0] dout_next;
    logic [31:0] dout_reg;

    always_comb
    begin
        if (prod2_reg[31])
        begin
            rnd = {1'b0, prod2_reg[31:8]} + 25'(prod2_reg[7] &&
                  ((prod2_reg[6:0] != 7'd0) || prod2_reg[8]));
            pr  = {rnd, 8'd0};
        end
        else
        begin
            rnd = {1'b0, prod2_reg[30:7]} + 25'(prod2_reg[6] &&
                  ((prod2_reg[5:0] != 6'd0) || prod2_reg[7]));
            pr  = {1'b0, rnd, 7'd0};
        end
        n = pr >> ush2_reg;

        case (code2_reg) inside
            rpfc_pkg::CONV_U8_F32, rpfc_pkg::CONV_F16_F32:
                dout_next = a2_reg;
            rpfc_pkg::CONV_U8_F16, rpfc_pkg::CONV_F32_F16:
                dout_next = {16'd0, sgn2_reg, 15'(q2_reg + {14'd0, inc2_reg})};
            rpfc_pkg::CONV_F16_U8, rpfc_pkg::CONV_F32_U8:
            begin
                if (zero2_reg)
                begin
                    dout_next = 32'd0;
                end
                else if (sat2_reg || n >= 33'd255)
                begin
                    dout_next = 32'd255;
                end
                else
                begin
                    dout_next = {24'd0, n[7:0]};
                end
            end
            default:
                dout_next = 32'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

// ----- hw/rtl/rgba_pixel_format_converter_top.sv -----
// top level of the rgba pixel format converter
// depends on rpfc_pkg, rpfc_ctrl and rpfc_channel
//
// usage:
//   s_axis carries one pixel per request: tuser holds the conversion code,
//   tdata the four channels, each right aligned in 32 bits.
//   m_axis returns the converted pixel in the same layout, upper bits zero.
//   codes: 0 u8->f32, 1 f16->f32, 2 u8->f16, 3 f32->f16, 4 f16->u8,
//   5 f32->u8; codes 6 and 7 give all zero channels.
//   a request accepted into the first pipeline register moves on through the
//   second and third, where it raises m_axis_tvalid; the three pipeline
//   registers take one pixel every cycle while m_axis_tready is high.
//   each stage holds its valid bit and loads only when it is empty or the
//   stage after it can load, so a stalled receiver fills the pipe from the
//   end and bubbles close up; s_axis_tready drops only when all three are full.
//   reset clears the valid bits; the pipe comes out of reset empty.
module rgba_pixel_format_converter_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // in_red, in_green, in_blue, in_alpha
    input  logic [2:0]   s_axis_tuser,  // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata   // out_red, out_green, out_blue, out_alpha
);

    rpfc_pkg::rpfc_en_t en;

    rpfc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .out_ready (m_axis_tready),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .en        (en)
    );

    for (genvar c = 0; c < 4; c++)
    begin : g_chan
        rpfc_channel u_chan
        (
            .clk      (clk),
            .en       (en),
            .req_type (s_axis_tuser),
            .din      (s_axis_tdata[c*32 +: 32]),
            .dout     (m_axis_tdata[c*32 +: 32])
        );
    end

endmodule

// ----- hw/rtl/rpfc_checker.sv -----
// port level checks for the rgba pixel format converter
// depends on rgba_pixel_format_converter_top_macros.svh; bound to the top level
`include "rgba_pixel_format_converter_top_macros.svh"

module rpfc_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    // stalled result holds its data
    `RPFC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "output changed under stall")

    // a draining output never blocks the input
    `RPFC_ASSERT(a_ready_flow, m_axis_tready |-> s_axis_tready, "input blocked while output drains")

    // with the receiver ready an accepted request passes through the pipeline and raises m_axis_tvalid
    `RPFC_ASSERT_NEXT(a_latency, s_axis_tvalid && s_axis_tready ##1 m_axis_tready ##1 m_axis_tready, m_axis_tvalid, "result missing after three cycles")

endmodule

bind rgba_pixel_format_converter_top rpfc_checker u_rpfc_checker (.*);
